/* src/kufef_pkg.sv */
// Package for the union-find edge filter: fixed field widths, controller
// states, and the command and status structs between controller and datapath.
// No dependencies.
package kufef_pkg;

    localparam int VCOUNT_W   = 11;
    localparam int ENDPOINT_W = 11;
    localparam int WEIGHT_W   = 32;
    localparam int TOTAL_W    = 10;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 64;
    localparam int M_TUSER_W  = 3;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;
    localparam logic [VCOUNT_W-1:0] VCOUNT_MIN   = 11'd2;

    typedef enum logic [3:0] {
        ST_RST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_WALK_A,
        ST_COMP_A,
        ST_WALK_B,
        ST_COMP_B,
        ST_JOIN_CHILD,
        ST_JOIN_ROOT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ENDPOINT,
        PTR_LINK
    } t_ptr_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_COMPRESS,
        WR_JOIN_CHILD,
        WR_JOIN_ROOT
    } t_wr_op;

    typedef struct packed {
        logic    load_in;
        logic    clr_init;
        t_ptr_op ptr_op;
        logic    ep_sel_b;
        logic    save_root;
        logic    root_sel_b;
        t_wr_op  wr_op;
        logic    count_inc;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic new_run;
        logic clr_last;
        logic edge_skip;
        logic link_is_root;
        logic ptr_at_root_a;
        logic ptr_at_root_b;
        logic same_root;
        logic out_free;
    } t_status;

endpackage

/* src/kruskal_union_find_edge_filter_core.sv */
// Kruskal edge filter: union-find with path compression and weighted union over
// vertices 1..vertex_count (clamped to 2..MAX_VERTICES), one request at a time.
// For each endpoint a request walks the parent links to its root and then
// compresses that path, stepping through the single-read, registered link
// memory. A request whose edge joins two sets then writes the child link and
// the new root size; one whose endpoints already share a root skips these
// writes. A bad endpoint or a complete forest skips the walk altogether.
// A request with new_run set first sweeps the memory. After reset the same
// sweep runs before the first request. A finished result waits in the output
// register while the next request enters, and a result held by the sink
// stretches the request by the stall.
// Depends on kufef_pkg, kufef_ctrl, kufef_datapath and kufef_ram.
module kruskal_union_find_edge_filter_core
    import kufef_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [VCOUNT_W-1:0]  i_cfg_wdata,   // vertex_count
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,     // endpoint_a, endpoint_b, weight
    input  logic [S_TUSER_W-1:0] i_s_tuser,     // new_run
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,     // accepted_total, edge_a, edge_b, edge_weight
    output logic [M_TUSER_W-1:0] o_m_tuser      // accepted, bad_vertex, forest_complete
);

    t_cmd    cmd;
    t_status status;

    kufef_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    kufef_datapath #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

/* src/kufef_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kufef_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/kufef_ctrl.sv */
// Controller for the union-find edge filter: sequences clear, find,
// path compression, union and result hand-off. Depends on kufef_pkg.
module kufef_ctrl
    import kufef_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.new_run) begin
                    n_state = ST_CLEAR;
                end else if (i_status.edge_skip) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_WALK_A;
                end
            end
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_CHECK;
            end
            ST_WALK_A: begin
                if (i_status.link_is_root) n_state = ST_COMP_A;
            end
            ST_COMP_A: begin
                if (i_status.ptr_at_root_a) n_state = ST_WALK_B;
            end
            ST_WALK_B: begin
                if (i_status.link_is_root) n_state = ST_COMP_B;
            end
            ST_COMP_B: begin
                if (i_status.ptr_at_root_b) begin
                    n_state = i_status.same_root ? ST_DONE : ST_JOIN_CHILD;
                end
            end
            ST_JOIN_CHILD: n_state = ST_JOIN_ROOT;
            ST_JOIN_ROOT:  n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_RST_CLEAR: o_cmd.wr_op = WR_CLEAR;
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            ST_CHECK: begin
                if (i_status.new_run) begin
                    o_cmd.clr_init = 1'b1;
                end else if (!i_status.edge_skip) begin
                    o_cmd.ptr_op = PTR_ENDPOINT;
                end
            end
            ST_CLEAR: o_cmd.wr_op = WR_CLEAR;
            ST_WALK_A: begin
                if (i_status.link_is_root) begin
                    o_cmd.save_root = 1'b1;
                    o_cmd.ptr_op    = PTR_ENDPOINT;
                end else begin
                    o_cmd.ptr_op = PTR_LINK;
                end
            end
            ST_COMP_A: begin
                if (i_status.ptr_at_root_a) begin
                    o_cmd.ptr_op   = PTR_ENDPOINT;
                    o_cmd.ep_sel_b = 1'b1;
                end else begin
                    o_cmd.wr_op  = WR_COMPRESS;
                    o_cmd.ptr_op = PTR_LINK;
                end
            end
            ST_WALK_B: begin
                o_cmd.ep_sel_b   = 1'b1;
                o_cmd.root_sel_b = 1'b1;
                if (i_status.link_is_root) begin
                    o_cmd.save_root = 1'b1;
                    o_cmd.ptr_op    = PTR_ENDPOINT;
                end else begin
                    o_cmd.ptr_op = PTR_LINK;
                end
            end
            ST_COMP_B: begin
                o_cmd.ep_sel_b   = 1'b1;
                o_cmd.root_sel_b = 1'b1;
                if (!i_status.ptr_at_root_b) begin
                    o_cmd.wr_op  = WR_COMPRESS;
                    o_cmd.ptr_op = PTR_LINK;
                end
            end
            ST_JOIN_CHILD: o_cmd.wr_op = WR_JOIN_CHILD;
            ST_JOIN_ROOT: begin
                o_cmd.wr_op     = WR_JOIN_ROOT;
                o_cmd.count_inc = 1'b1;
            end
            ST_DONE: o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* src/kufef_datapath.sv */
// Datapath for the union-find edge filter: request registers, link memory,
// walk pointer, roots, accepted count and output register.
// Depends on kufef_pkg and kufef_ram.
module kufef_datapath
    import kufef_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [VCOUNT_W-1:0]  i_cfg_wdata,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser,
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int LW = VW + 1;

    logic [VCOUNT_W-1:0]   r_vcount;
    logic [VCOUNT_W-1:0]   n_eff;
    logic                  r_new_run;
    logic [ENDPOINT_W-1:0] r_ep_a;
    logic [ENDPOINT_W-1:0] r_ep_b;
    logic [WEIGHT_W-1:0]   r_weight;
    logic [AW-1:0]         r_count;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_acc;
    logic [VW-1:0]         r_ptr;
    logic [VW-1:0]         n_ptr;
    logic [VW-1:0]         r_root_a;
    logic [VW-1:0]         r_root_b;
    logic signed [LW-1:0]  r_size_a;
    logic signed [LW-1:0]  r_size_b;
    logic signed [LW-1:0]  total;
    logic [LW-1:0]         rdata;
    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [LW-1:0]         wdata;
    logic [VW-1:0]         vtx_a;
    logic [VW-1:0]         vtx_b;
    logic [VW-1:0]         root_sel;
    logic [VW-1:0]         join_child;
    logic [VW-1:0]         join_parent;
    logic                  bad;
    logic                  complete;
    logic [31:0]           count_wide;
    logic                  r_m_tvalid;
    logic [M_TDATA_W-1:0]  r_m_tdata;
    logic [M_TUSER_W-1:0]  r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (i_cfg_we) begin
            r_vcount <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_vcount < VCOUNT_MIN) begin
            n_eff = VCOUNT_MIN;
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            n_eff = VCOUNT_W'(MAX_VERTICES);
        end else begin
            n_eff = r_vcount;
        end
    end

    assign bad = (r_ep_a == '0) || (r_ep_a > n_eff) || (r_ep_b == '0) || (r_ep_b > n_eff);
    assign count_wide = 32'(r_count);
    assign complete   = count_wide >= 32'(n_eff - VCOUNT_W'(1));

    assign vtx_a    = VW'(r_ep_a);
    assign vtx_b    = VW'(r_ep_b);
    assign root_sel = i_cmd.root_sel_b ? r_root_b : r_root_a;
    assign total    = r_size_a + r_size_b;
    assign join_child  = (r_size_a > r_size_b) ? r_root_a : r_root_b;
    assign join_parent = (r_size_a > r_size_b) ? r_root_b : r_root_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ep_a   <= i_s_tdata[ENDPOINT_W-1:0];
            r_ep_b   <= i_s_tdata[2*ENDPOINT_W-1:ENDPOINT_W];
            r_weight <= i_s_tdata[2*ENDPOINT_W+WEIGHT_W-1:2*ENDPOINT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_run  <= 1'b0;
            r_count    <= '0;
            r_clr_addr <= '0;
            r_acc      <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_new_run <= i_s_tuser[0];
                r_acc     <= 1'b0;
            end else if (i_cmd.clr_init) begin
                r_new_run <= 1'b0;
            end
            if (i_cmd.clr_init) begin
                r_count    <= '0;
                r_clr_addr <= '0;
            end else begin
                if (i_cmd.wr_op == WR_CLEAR) r_clr_addr <= r_clr_addr + AW'(1);
                if (i_cmd.count_inc) begin
                    r_count <= r_count + AW'(1);
                    r_acc   <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_HOLD:     n_ptr = r_ptr;
            PTR_ENDPOINT: n_ptr = i_cmd.ep_sel_b ? vtx_b : vtx_a;
            PTR_LINK:     n_ptr = rdata[VW-1:0];
            default:      n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.save_root) begin
            if (i_cmd.root_sel_b) begin
                r_root_b <= r_ptr;
                r_size_b <= signed'(rdata);
            end else begin
                r_root_a <= r_ptr;
                r_size_a <= signed'(rdata);
            end
        end
    end

    assign raddr = AW'(n_ptr - VW'(1));

    always_comb begin
        we    = 1'b0;
        waddr = AW'(r_ptr - VW'(1));
        wdata = LW'(root_sel);
        case (i_cmd.wr_op)
            WR_NONE: we = 1'b0;
            WR_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_addr;
                wdata = '1;
            end
            WR_COMPRESS: we = 1'b1;
            WR_JOIN_CHILD: begin
                we    = 1'b1;
                waddr = AW'(join_child - VW'(1));
                wdata = LW'(join_parent);
            end
            WR_JOIN_ROOT: begin
                we    = 1'b1;
                waddr = AW'(join_parent - VW'(1));
                wdata = total;
            end
            default: we = 1'b0;
        endcase
    end

    kufef_ram #(
        .WIDTH(LW),
        .DEPTH(MAX_VERTICES)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tdata <= {r_weight, r_ep_b, r_ep_a, count_wide[TOTAL_W-1:0]};
            r_m_tuser <= {complete, bad, r_acc};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    always_comb begin
        o_status               = '0;
        o_status.new_run       = r_new_run;
        o_status.clr_last      = r_clr_addr == AW'(MAX_VERTICES - 1);
        o_status.edge_skip     = bad || complete;
        o_status.link_is_root  = rdata[LW-1];
        o_status.ptr_at_root_a = r_ptr == r_root_a;
        o_status.ptr_at_root_b = r_ptr == r_root_b;
        o_status.same_root     = r_root_a == r_root_b;
        o_status.out_free      = !r_m_tvalid || i_m_tready;
    end

    a_acc_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_m_tuser[0]) |-> !r_m_tuser[1])
        else $error("accepted edge reported with a bad endpoint");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ((r_count == $past(r_count) + AW'(1)) || $past(i_cmd.clr_init) || !$past(i_rst_n)))
        else $error("accepted count moved by more than one");

    a_compress_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == WR_COMPRESS) |-> (r_ptr != root_sel))
        else $error("path compression wrote a root");

    a_join_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_op == WR_JOIN_CHILD) |-> (r_root_a != r_root_b))
        else $error("union of a set with itself");

endmodule
